@@ rtl/core/csc_pkg.sv @@
// Shared types, constants and calendar tables for the calendar seconds converter.
package csc_pkg;

    localparam int unsigned SecsW  = 32;
    localparam int unsigned YearW  = 12;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned HourW  = 5;
    localparam int unsigned MinW   = 6;
    localparam int unsigned SecW   = 6;
    localparam int unsigned WdayW  = 3;

    localparam logic [MonthW-1:0] LastMonth = 4'd11;
    localparam logic [YearW-1:0]  EpochYear = 12'd2000;

    // Day index of 2100-03-01; from there on one virtual Feb 29 is inserted.
    localparam logic [15:0] Mar2100 = 16'd36584;

    // Seconds count handed from the compose stages to the split stages.
    typedef struct packed {
        logic             vld;
        logic [SecsW-1:0] secs;
        logic             ovf;
    } t_cvt;

    // Days before the first of month m in a common year.
    function automatic logic [8:0] cum_days(input logic [MonthW-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/csc_compose.sv @@
// Four-stage front end: calendar fields to a saturated seconds count, or seconds pass-through.
module csc_compose import csc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic              i_kind,
    input  logic [SecsW-1:0]  i_seconds_in,
    input  logic [YearW-1:0]  i_year,
    input  logic [MonthW-1:0] i_month,
    input  logic [DayW-1:0]   i_day,
    input  logic [HourW-1:0]  i_hour,
    input  logic [MinW-1:0]   i_minute,
    input  logic [SecW-1:0]   i_second,
    output t_cvt              o_cvt
);

    // stage 1: leap-count quotients by reciprocal multiply, time of day
    logic              r1_vld, r1_kind;
    logic [SecsW-1:0]  r1_secs;
    logic [12:0]       r1_a;
    logic [YearW-1:0]  r1_y;
    logic [5:0]        r1_qa100, r1_qy100;
    logic [3:0]        r1_qa400, r1_qy400;
    logic [MonthW-1:0] r1_m;
    logic [DayW-1:0]   r1_day;
    logic [16:0]       r1_tsec;

    logic [12:0]       n1_a;
    logic [24:0]       n1_pa, n1_py;
    logic [MonthW-1:0] n1_m;
    logic [16:0]       n1_tsec;

    always_comb begin
        n1_a    = 13'(i_year) + 13'd399;
        n1_pa   = 25'(n1_a) * 25'd5243;
        n1_py   = 25'(i_year) * 25'd5243;
        n1_m    = (i_month > LastMonth) ? LastMonth : i_month;
        n1_tsec = 17'(i_hour) * 17'd3600 + 17'(i_minute) * 17'd60 + 17'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_kind  <= i_kind;
        r1_secs  <= i_seconds_in;
        r1_a     <= n1_a;
        r1_y     <= i_year;
        r1_qa100 <= n1_pa[24:19];
        r1_qa400 <= n1_pa[24:21];
        r1_qy100 <= n1_py[24:19];
        r1_qy400 <= n1_py[24:21];
        r1_m     <= n1_m;
        r1_day   <= i_day;
        r1_tsec  <= n1_tsec;
    end

    // stage 2: signed day count from the epoch
    logic               r2_vld, r2_kind;
    logic [SecsW-1:0]   r2_secs;
    logic signed [22:0] r2_days;
    logic [16:0]        r2_tsec;

    logic        n2_leap;
    logic [22:0] n2_pos, n2_neg;

    always_comb begin
        n2_leap = (r1_y[1:0] == 2'd0)
                  && !((r1_y == YearW'(r1_qy100) * 12'd100)
                       && (r1_y != YearW'(r1_qy400 * 12'd400)));
        n2_pos  = 23'(r1_a) * 23'd365 + 23'(r1_a >> 2) + 23'(r1_qa400)
                  + 23'(cum_days(r1_m)) + 23'(n2_leap && (r1_m > 4'd1)) + 23'(r1_day);
        n2_neg  = 23'(r1_qa100) + 23'd876217;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_kind <= r1_kind;
        r2_secs <= r1_secs;
        r2_days <= $signed(n2_pos) - $signed(n2_neg);
        r2_tsec <= r1_tsec;
    end

    // stage 3: days times seconds per day
    logic               r3_vld, r3_kind;
    logic [SecsW-1:0]   r3_secs;
    logic signed [40:0] r3_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_kind  <= r2_kind;
        r3_secs  <= r2_secs;
        r3_total <= 41'(r2_days) * 41'sd86400 + $signed({24'd0, r2_tsec});
    end

    // stage 4: saturate and select
    t_cvt r4_cvt, n4_cvt;

    always_comb begin
        n4_cvt.vld  = r3_vld;
        n4_cvt.secs = r3_secs;
        n4_cvt.ovf  = 1'b0;
        if (r3_kind) begin
            if (r3_total < 41'sd0) begin
                n4_cvt.secs = '0;
                n4_cvt.ovf  = 1'b1;
            end else if (r3_total > 41'sd4294967295) begin
                n4_cvt.secs = '1;
                n4_cvt.ovf  = 1'b1;
            end else begin
                n4_cvt.secs = r3_total[SecsW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_cvt.vld <= 1'b0;
        end else begin
            r4_cvt.vld <= n4_cvt.vld;
        end
        r4_cvt.secs <= n4_cvt.secs;
        r4_cvt.ovf  <= n4_cvt.ovf;
    end

    assign o_cvt = r4_cvt;

endmodule

@@ rtl/core/csc_split.sv @@
// Six-stage back end: seconds count to date, time of day and weekday.
module csc_split import csc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cvt              i_cvt,
    output logic              o_vld,
    output logic [SecsW-1:0]  o_secs,
    output logic [YearW-1:0]  o_year,
    output logic [MonthW-1:0] o_month,
    output logic [DayW-1:0]   o_day,
    output logic [HourW-1:0]  o_hour,
    output logic [MinW-1:0]   o_minute,
    output logic [SecW-1:0]   o_second,
    output logic [WdayW-1:0]  o_weekday,
    output logic              o_ovf
);

    // stage 5: days = secs / 86400 as (secs >> 7) / 675
    t_cvt        r5_cvt;
    logic [15:0] r5_days;
    logic [50:0] n5_p;

    assign n5_p = 51'(i_cvt.secs[SecsW-1:7]) * 51'd50903317;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_cvt.vld <= 1'b0;
        end else begin
            r5_cvt.vld <= i_cvt.vld;
        end
        r5_cvt.secs <= i_cvt.secs;
        r5_cvt.ovf  <= i_cvt.ovf;
        r5_days     <= n5_p[50:35];
    end

    // stage 6: seconds of day, leap-adjusted day index, weekday operand
    t_cvt        r6_cvt;
    logic [16:0] r6_rest;
    logic [15:0] r6_dp, r6_d5;
    logic [SecsW-1:0] n6_dsec;

    assign n6_dsec = SecsW'(r5_days) * 32'd86400;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_cvt.vld <= 1'b0;
        end else begin
            r6_cvt.vld <= r5_cvt.vld;
        end
        r6_cvt.secs <= r5_cvt.secs;
        r6_cvt.ovf  <= r5_cvt.ovf;
        r6_rest     <= 17'(r5_cvt.secs - n6_dsec);
        r6_dp       <= r5_days + 16'(r5_days >= Mar2100);
        r6_d5       <= r5_days + 16'd5;
    end

    // stage 7: quotients for hour, four-year cycle and week
    t_cvt        r7_cvt;
    logic [16:0] r7_rest;
    logic [15:0] r7_dp, r7_d5;
    logic [4:0]  r7_hq;
    logic [5:0]  r7_q4;
    logic [12:0] r7_q7;
    logic [25:0] n7_ph;
    logic [32:0] n7_p4, n7_p7;

    always_comb begin
        n7_ph = 26'(r6_rest[16:4]) * 26'd4661;
        n7_p4 = 33'(r6_dp) * 33'd91868;
        n7_p7 = 33'(r6_d5) * 33'd74899;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_cvt.vld <= 1'b0;
        end else begin
            r7_cvt.vld <= r6_cvt.vld;
        end
        r7_cvt.secs <= r6_cvt.secs;
        r7_cvt.ovf  <= r6_cvt.ovf;
        r7_rest     <= r6_rest;
        r7_dp       <= r6_dp;
        r7_d5       <= r6_d5;
        r7_hq       <= n7_ph[24:20];
        r7_q4       <= n7_p4[32:27];
        r7_q7       <= n7_p7[31:19];
    end

    // stage 8: remainders
    t_cvt             r8_cvt;
    logic [11:0]      r8_rh;
    logic [10:0]      r8_r4;
    logic [5:0]       r8_q4;
    logic [HourW-1:0] r8_hour;
    logic [WdayW-1:0] r8_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_cvt.vld <= 1'b0;
        end else begin
            r8_cvt.vld <= r7_cvt.vld;
        end
        r8_cvt.secs <= r7_cvt.secs;
        r8_cvt.ovf  <= r7_cvt.ovf;
        r8_rh       <= 12'(r7_rest - 17'(r7_hq) * 17'd3600);
        r8_r4       <= 11'(r7_dp - 16'(r7_q4) * 16'd1461);
        r8_q4       <= r7_q4;
        r8_hour     <= r7_hq;
        r8_wd       <= 3'(r7_d5 - 16'(r7_q7) * 16'd7);
    end

    // stage 9: minute quotient, year and day of year
    t_cvt             r9_cvt;
    logic [11:0]      r9_rh;
    logic [MinW-1:0]  r9_min;
    logic [YearW-1:0] r9_year;
    logic [8:0]       r9_doy;
    logic             r9_leap;
    logic [HourW-1:0] r9_hour;
    logic [WdayW-1:0] r9_wd;

    logic [20:0] n9_pm;
    logic [1:0]  n9_yin;
    logic [10:0] n9_base;

    always_comb begin
        n9_pm = 21'(r8_rh[11:2]) * 21'd1093;
        if (r8_r4 >= 11'd1096) begin
            n9_yin  = 2'd3;
            n9_base = 11'd1096;
        end else if (r8_r4 >= 11'd731) begin
            n9_yin  = 2'd2;
            n9_base = 11'd731;
        end else if (r8_r4 >= 11'd366) begin
            n9_yin  = 2'd1;
            n9_base = 11'd366;
        end else begin
            n9_yin  = 2'd0;
            n9_base = 11'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_cvt.vld <= 1'b0;
        end else begin
            r9_cvt.vld <= r8_cvt.vld;
        end
        r9_cvt.secs <= r8_cvt.secs;
        r9_cvt.ovf  <= r8_cvt.ovf;
        r9_rh       <= r8_rh;
        r9_min      <= n9_pm[19:14];
        r9_year     <= EpochYear + YearW'({r8_q4, 2'b00}) + YearW'(n9_yin);
        r9_doy      <= 9'(r8_r4 - n9_base);
        r9_leap     <= (n9_yin == 2'd0);
        r9_hour     <= r8_hour;
        r9_wd       <= r8_wd;
    end

    // stage 10: second, month and day of month; output register
    logic [MonthW-1:0] n10_m;
    logic [8:0]        n10_cum;

    always_comb begin
        n10_m = '0;
        for (int i = 1; i <= 11; i++) begin
            if (9'(cum_days(MonthW'(i))) + 9'(r9_leap && (i > 1)) <= r9_doy) begin
                n10_m = MonthW'(i);
            end
        end
        n10_cum = cum_days(n10_m) + 9'(r9_leap && (n10_m > 4'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r9_cvt.vld;
        end
        o_secs    <= r9_cvt.secs;
        o_ovf     <= r9_cvt.ovf;
        o_year    <= r9_year;
        o_month   <= n10_m;
        o_day     <= DayW'(r9_doy - n10_cum + 9'd1);
        o_hour    <= r9_hour;
        o_minute  <= r9_min;
        o_second  <= SecW'(r9_rh - 12'(r9_min) * 12'd60);
        o_weekday <= r9_wd;
    end

endmodule

@@ rtl/core/calendar_seconds_converter.sv @@
// Top level of the calendar seconds converter: compose pipeline feeding split pipeline.
//
//  channel   handshake           payload
//  command   start (busy low)    i_kind, i_seconds_in, i_in_year .. i_in_second
//  result    o_valid strobe      o_seconds_out, o_out_year .. o_weekday, o_overflow
//
// One command per cycle; each result passes through 4 compose stages and 6 split stages.
// busy is always low: results cannot be held off, so nothing ever stalls.
// Synchronous reset clears the stage valid bits only.
module calendar_seconds_converter import csc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [SecsW-1:0]  i_seconds_in,
    input  logic [YearW-1:0]  i_in_year,
    input  logic [MonthW-1:0] i_in_month,
    input  logic [DayW-1:0]   i_in_day,
    input  logic [HourW-1:0]  i_in_hour,
    input  logic [MinW-1:0]   i_in_minute,
    input  logic [SecW-1:0]   i_in_second,
    output logic              o_valid,
    output logic [SecsW-1:0]  o_seconds_out,
    output logic [YearW-1:0]  o_out_year,
    output logic [MonthW-1:0] o_out_month,
    output logic [DayW-1:0]   o_out_day,
    output logic [HourW-1:0]  o_out_hour,
    output logic [MinW-1:0]   o_out_minute,
    output logic [SecW-1:0]   o_out_second,
    output logic [WdayW-1:0]  o_weekday,
    output logic              o_overflow
);

    t_cvt cvt;

    assign busy = 1'b0;

    csc_compose u_compose (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (start),
        .i_kind       (i_kind),
        .i_seconds_in (i_seconds_in),
        .i_year       (i_in_year),
        .i_month      (i_in_month),
        .i_day        (i_in_day),
        .i_hour       (i_in_hour),
        .i_minute     (i_in_minute),
        .i_second     (i_in_second),
        .o_cvt        (cvt)
    );

    csc_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cvt     (cvt),
        .o_vld     (o_valid),
        .o_secs    (o_seconds_out),
        .o_year    (o_out_year),
        .o_month   (o_out_month),
        .o_day     (o_out_day),
        .o_hour    (o_out_hour),
        .o_minute  (o_out_minute),
        .o_second  (o_out_second),
        .o_weekday (o_weekday),
        .o_ovf     (o_overflow)
    );

endmodule

@@ verif/tb_calendar_seconds_converter.sv @@
// Self-checking testbench for the calendar seconds converter.
module tb_calendar_seconds_converter;
    import csc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KindSplit   = 1'b0;
    localparam logic KindCompose = 1'b1;
    localparam int   Latency     = 10;

    typedef struct packed {
        logic              kind;
        logic [SecsW-1:0]  secs;
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
    } t_cmd;

    typedef struct packed {
        logic [SecsW-1:0]  secs;
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [SecW-1:0]   second;
        logic [WdayW-1:0]  wday;
        logic              ovf;
    } t_date;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_cmd              cmd = '0;
    logic              valid;
    t_date             got;

    t_cmd              pending_cmds[$];
    t_date             expected_dates[$];
    int                idle_pct = 0;
    int                mismatches = 0;
    bit                stim_done = 1'b0;

    calendar_seconds_converter DUT (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_kind(cmd.kind), .i_seconds_in(cmd.secs), .i_in_year(cmd.year),
        .i_in_month(cmd.month), .i_in_day(cmd.day), .i_in_hour(cmd.hour),
        .i_in_minute(cmd.minute), .i_in_second(cmd.second),
        .o_valid(valid), .o_seconds_out(got.secs), .o_out_year(got.year),
        .o_out_month(got.month), .o_out_day(got.day), .o_out_hour(got.hour),
        .o_out_minute(got.minute), .o_out_second(got.second),
        .o_weekday(got.wday), .o_overflow(got.ovf)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap(longint y);
        return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    endfunction

    function automatic int month_len(int m, longint y);
        int len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return len[m] + ((m == 1 && is_leap(y)) ? 1 : 0);
    endfunction

    // Days from the epoch to Jan 1 of year y; shifted by a 400-year cycle.
    function automatic longint epoch_days_to_year(longint y);
        longint a;
        longint b;
        a = y + 399;
        b = 2000 + 399;
        return (365 * a + a / 4 - a / 100 + a / 400) - (365 * b + b / 4 - b / 100 + b / 400);
    endfunction

    function automatic t_date calendar_of(t_cmd c);
        t_date  r;
        longint total;
        longint days;
        longint y;
        int     m;
        int     mo;
        longint d;
        longint rest;
        r = '0;
        if (c.kind == KindSplit) begin
            r.secs = c.secs;
        end else begin
            mo = (c.month > LastMonth) ? int'(LastMonth) : int'(c.month);
            days = epoch_days_to_year(c.year);
            for (int i = 0; i < mo; i++) days += month_len(i, c.year);
            days += longint'(c.day) - 1;
            total = days * 86400 + longint'(c.hour) * 3600 + longint'(c.minute) * 60
                    + longint'(c.second);
            if (total < 0) begin
                r.secs = '0;
                r.ovf = 1'b1;
            end else if (total > 64'hFFFF_FFFF) begin
                r.secs = '1;
                r.ovf = 1'b1;
            end else begin
                r.secs = total[31:0];
            end
        end
        days = r.secs / 86400;
        rest = r.secs % 86400;
        y = 2000;
        d = days;
        while (d >= (is_leap(y) ? 366 : 365)) begin
            d -= is_leap(y) ? 366 : 365;
            y++;
        end
        m = 0;
        while (m < 11 && d >= month_len(m, y)) begin
            d -= month_len(m, y);
            m++;
        end
        r.year = y[YearW-1:0];
        r.month = m[MonthW-1:0];
        r.day = DayW'(d + 1);
        r.hour = HourW'(rest / 3600);
        r.minute = MinW'((rest / 60) % 60);
        r.second = SecW'(rest % 60);
        r.wday = WdayW'((days + 5) % 7);
        return r;
    endfunction

    // driver: one transfer per start & !busy edge
    always @(negedge clk) begin
        if (rst_n && !(start && busy)) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && start && !busy) expected_dates.push_back(calendar_of(cmd));
    end

    // monitor
    always @(posedge clk) begin
        t_date exp_d;
        if (rst_n && valid) begin
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_d = expected_dates.pop_front();
                if (exp_d !== got) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", exp_d, got);
                end
            end
        end
    end

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c = '0;
        c.kind = 1'($urandom_range(1));
        c.secs = $urandom;
        c.year = ($urandom_range(9) == 0) ? YearW'($urandom) : YearW'($urandom_range(2135, 1990));
        c.month = ($urandom_range(9) == 0) ? MonthW'($urandom) : MonthW'($urandom_range(11));
        c.day = ($urandom_range(9) == 0) ? DayW'($urandom) : DayW'($urandom_range(28, 1));
        c.hour = ($urandom_range(9) == 0) ? HourW'($urandom) : HourW'($urandom_range(23));
        c.minute = ($urandom_range(9) == 0) ? MinW'($urandom) : MinW'($urandom_range(59));
        c.second = ($urandom_range(9) == 0) ? SecW'($urandom) : SecW'($urandom_range(59));
        return c;
    endfunction

    function automatic t_cmd compose_cmd(int y, int mo, int d, int h, int mi, int s);
        t_cmd c;
        c = '0;
        c.kind = KindCompose;
        c.year = YearW'(y);
        c.month = MonthW'(mo);
        c.day = DayW'(d);
        c.hour = HourW'(h);
        c.minute = MinW'(mi);
        c.second = SecW'(s);
        c.secs = $urandom;
        return c;
    endfunction

    function automatic t_cmd split_cmd(logic [31:0] s);
        t_cmd c;
        c = rand_cmd();
        c.kind = KindSplit;
        c.secs = s;
        return c;
    endfunction

    initial begin
        int phase_idle[4] = '{0, 52, 0, 21};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // directed: field extremes and special cases
        pending_cmds.push_back(split_cmd(32'd0));
        pending_cmds.push_back(split_cmd(32'hFFFF_FFFF));
        pending_cmds.push_back(split_cmd(32'd3_155_760_000));       // 2100-01-01
        pending_cmds.push_back(split_cmd(32'd3_160_857_599));       // end of Feb 2100
        pending_cmds.push_back(compose_cmd(2000, 0, 1, 0, 0, 0));
        pending_cmds.push_back(compose_cmd(2136, 1, 7, 6, 28, 15));  // exactly max
        pending_cmds.push_back(compose_cmd(2136, 1, 7, 6, 28, 16));  // too large
        pending_cmds.push_back(compose_cmd(4095, 15, 31, 31, 63, 63));
        pending_cmds.push_back(compose_cmd(1999, 11, 31, 23, 59, 59)); // below zero
        pending_cmds.push_back(compose_cmd(0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(compose_cmd(2000, 0, 0, 0, 0, 0));
        pending_cmds.push_back(compose_cmd(2001, 0, 0, 0, 0, 0));     // day zero
        pending_cmds.push_back(compose_cmd(2100, 1, 29, 0, 0, 0));    // no leap day 2100
        pending_cmds.push_back(compose_cmd(2004, 1, 29, 12, 0, 0));
        pending_cmds.push_back(compose_cmd(2001, 1, 30, 24, 60, 60)); // rollovers
        pending_cmds.push_back(compose_cmd(2020, 12, 15, 1, 2, 3));   // month clamps
        pending_cmds.push_back(compose_cmd(2099, 11, 31, 23, 59, 59));
        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            for (int i = 0; i < 300; i++) pending_cmds.push_back(rand_cmd());
            wait (pending_cmds.size() == 0);
        end
        @(posedge clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done && expected_dates.size() == 0);
        repeat (Latency + 5) @(posedge clk);
        if (mismatches == 0 && expected_dates.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
